@@ rtl/epr_pkg.sv @@
// ----------------------------------------------------------------------------
// Edit position remapper package
// Shared widths, codes and record types for the edit remapper cell chain.
// ----------------------------------------------------------------------------
package epr_pkg;

   // field and position widths
   localparam int FIELD_W       = 16;
   localparam int POS_BITS      = 16;
   localparam logic [63:0] POS_MAX = (64'd1 << POS_BITS) - 64'd1;

   // default table depth
   localparam int EPR_MAX_EDITS = 64;

   // item kinds
   localparam logic [1:0] KIND_CLEAR    = 2'd0;
   localparam logic [1:0] KIND_APPEND   = 2'd1;
   localparam logic [1:0] KIND_MAP_FWD  = 2'd2;
   localparam logic [1:0] KIND_MAP_BACK = 2'd3;

   // result status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   typedef struct packed {
      logic [FIELD_W-1:0] bl;
      logic [FIELD_W-1:0] bc;
      logic [FIELD_W-1:0] el;
      logic [FIELD_W-1:0] ec;
   } epr_range_type;

   typedef struct packed {
      epr_range_type orig_rng;
      epr_range_type xfrm_rng;
   } epr_edit_type;

   // query token handed from cell to cell
   typedef struct packed {
      logic               dir;         // 1: transformed back to original
      logic [FIELD_W-1:0] ln;
      logic [FIELD_W-1:0] col;
      logic               done;        // walk stopped
      logic               snap;
      logic [FIELD_W-1:0] snap_line;
      logic [FIELD_W-1:0] snap_col;
      logic               track_valid;
      logic [FIELD_W-1:0] track_line;
   } epr_tok_type;

   typedef struct packed {
      logic [FIELD_W-1:0] mapped_line;
      logic [FIELD_W-1:0] mapped_col;
      logic               snapped;
      logic [1:0]         status;
   } epr_result_type;

endpackage

@@ rtl/epr_if.sv @@
// ----------------------------------------------------------------------------
// Edit position remapper channels
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface epr_req_if import epr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [FIELD_W-1:0] orig_begin_line;
   logic [FIELD_W-1:0] orig_begin_col;
   logic [FIELD_W-1:0] orig_end_line;
   logic [FIELD_W-1:0] orig_end_col;
   logic [FIELD_W-1:0] new_begin_line;
   logic [FIELD_W-1:0] new_begin_col;
   logic [FIELD_W-1:0] new_end_line;
   logic [FIELD_W-1:0] new_end_col;
   logic [FIELD_W-1:0] query_line;
   logic [FIELD_W-1:0] query_col;

   modport source (
      output valid, kind, orig_begin_line, orig_begin_col, orig_end_line, orig_end_col,
             new_begin_line, new_begin_col, new_end_line, new_end_col, query_line, query_col,
      input  ready
   );
   modport sink (
      input  valid, kind, orig_begin_line, orig_begin_col, orig_end_line, orig_end_col,
             new_begin_line, new_begin_col, new_end_line, new_end_col, query_line, query_col,
      output ready
   );
endinterface

interface epr_rsp_if import epr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] mapped_line;
   logic [FIELD_W-1:0] mapped_col;
   logic               snapped;
   logic [1:0]         status;

   modport source (
      output valid, mapped_line, mapped_col, snapped, status,
      input  ready
   );
   modport sink (
      input  valid, mapped_line, mapped_col, snapped, status,
      output ready
   );
endinterface

@@ rtl/epr_walk_cell.sv @@
// ----------------------------------------------------------------------------
// Edit remapper walk cell
// Holds one edit and applies it to the query token passing through.
// ----------------------------------------------------------------------------
module epr_walk_cell import epr_pkg::*; #(
   parameter int CNT_W   = 7,
   parameter int DELTA_W = 25
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  epr_edit_type              wr_edit,
   input  logic                      up_valid,
   input  epr_tok_type               up_tok,
   input  logic [CNT_W-1:0]          up_rem,
   input  logic signed [DELTA_W-1:0] up_line_delta,
   input  logic signed [DELTA_W-1:0] up_col_delta,
   output logic                      dn_valid,
   output epr_tok_type               dn_tok,
   output logic [CNT_W-1:0]          dn_rem,
   output logic signed [DELTA_W-1:0] dn_line_delta,
   output logic signed [DELTA_W-1:0] dn_col_delta
);

   epr_edit_type              edit_ff;
   logic                      valid_ff;
   epr_tok_type               tok_ff, tok_in;
   logic [CNT_W-1:0]          rem_ff, rem_in;
   logic signed [DELTA_W-1:0] ld_ff, ld_in, cd_ff, cd_in;

   epr_range_type             src, dst;
   logic                      is_before, is_inside, single;
   logic signed [FIELD_W+1:0] dl, dc;

   always_comb begin
      src = up_tok.dir ? edit_ff.xfrm_rng : edit_ff.orig_rng;
      dst = up_tok.dir ? edit_ff.orig_rng : edit_ff.xfrm_rng;

      is_before = (up_tok.ln < src.bl) || ((up_tok.ln == src.bl) && (up_tok.col < src.bc));

      if ((up_tok.ln > src.bl) && (up_tok.ln < src.el)) begin
         is_inside = 1'b1;
      end else if ((up_tok.ln == src.bl) && (up_tok.ln == src.el)) begin
         is_inside = (up_tok.col >= src.bc) && (up_tok.col < src.ec);
      end else if (up_tok.ln == src.bl) begin
         is_inside = (up_tok.col >= src.bc);
      end else if (up_tok.ln == src.el) begin
         is_inside = (up_tok.col < src.ec);
      end else begin
         is_inside = 1'b0;
      end

      // target length minus source length, for lines and columns
      dl = $signed({2'b00, dst.el}) - $signed({2'b00, dst.bl})
         - $signed({2'b00, src.el}) + $signed({2'b00, src.bl});
      dc = $signed({2'b00, dst.ec}) - $signed({2'b00, dst.bc})
         - $signed({2'b00, src.ec}) + $signed({2'b00, src.bc});
      single = (src.el == src.bl) && (dst.el == dst.bl);

      tok_in = up_tok;
      rem_in = up_rem;
      ld_in  = up_line_delta;
      cd_in  = up_col_delta;

      if (!up_tok.done && (up_rem != '0)) begin
         if (is_before) begin
            tok_in.done = 1'b1;
         end else if (is_inside) begin
            tok_in.done      = 1'b1;
            tok_in.snap      = 1'b1;
            tok_in.snap_line = dst.bl;
            tok_in.snap_col  = dst.bc;
         end else begin
            ld_in = up_line_delta + DELTA_W'(dl);
            if (single) begin
               if (up_tok.track_valid && (up_tok.track_line == src.bl)) begin
                  cd_in = up_col_delta + DELTA_W'(dc);
               end else begin
                  tok_in.track_valid = 1'b1;
                  tok_in.track_line  = src.bl;
                  cd_in              = DELTA_W'(dc);
               end
            end else begin
               tok_in.track_valid = 1'b0;
               cd_in              = '0;
            end
            rem_in = up_rem - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      rem_ff <= rem_in;
      ld_ff  <= ld_in;
      cd_ff  <= cd_in;
      if (wr_en) begin
         edit_ff <= wr_edit;
      end
   end

   assign dn_valid      = valid_ff;
   assign dn_tok        = tok_ff;
   assign dn_rem        = rem_ff;
   assign dn_line_delta = ld_ff;
   assign dn_col_delta  = cd_ff;

endmodule

@@ rtl/epr_resolve.sv @@
// ----------------------------------------------------------------------------
// Edit remapper resolve
// Turns the finished walk token into a clamped mapped position.
// ----------------------------------------------------------------------------
module epr_resolve import epr_pkg::*; #(
   parameter int DELTA_W = 25
) (
   input  epr_tok_type               tok,
   input  logic signed [DELTA_W-1:0] line_delta,
   input  logic signed [DELTA_W-1:0] col_delta,
   output epr_result_type            result
);

   localparam int SUM_W = DELTA_W + 1;
   localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(POS_MAX);

   logic signed [SUM_W-1:0] line_v, col_v;
   logic                    sat_l, sat_c;

   always_comb begin
      if (tok.snap) begin
         line_v = $signed(SUM_W'(tok.snap_line));
         col_v  = $signed(SUM_W'(tok.snap_col));
      end else begin
         line_v = $signed(SUM_W'(tok.ln)) + SUM_W'(line_delta);
         col_v  = $signed(SUM_W'(tok.col));
         if (tok.track_valid && (tok.track_line == tok.ln)) begin
            col_v = col_v + SUM_W'(col_delta);
         end
      end

      sat_l = 1'b0;
      if (line_v < 0) begin
         line_v = '0;
         sat_l  = 1'b1;
      end else if (line_v > MAX_S) begin
         line_v = MAX_S;
         sat_l  = 1'b1;
      end

      sat_c = 1'b0;
      if (col_v < 0) begin
         col_v = '0;
         sat_c = 1'b1;
      end else if (col_v > MAX_S) begin
         col_v = MAX_S;
         sat_c = 1'b1;
      end

      result.mapped_line = line_v[FIELD_W-1:0];
      result.mapped_col  = col_v[FIELD_W-1:0];
      result.snapped     = tok.snap;
      result.status      = (sat_l || sat_c) ? STAT_SAT : STAT_OK;
   end

endmodule

@@ rtl/edit_position_remapper_unit.sv @@
// ----------------------------------------------------------------------------
// Edit position remapper unit
// Table of text edits held in a row of cells; maps positions forward/back.
// ----------------------------------------------------------------------------
//
//   channel   | dir | handshake           | carries
//   ----------+-----+---------------------+-----------------------------------
//   req_chan  | in  | valid/ready         | kind, original/new ranges, query
//   rsp_chan  | out | valid/ready         | mapped line/col, snapped, status
//
// Clear and append results are registered at the transfer. For a query a token
// walks the row of cells one cell per cycle, through every cell, whatever the
// fill; the resolved result is registered as the token leaves the last cell.
// Reset clears the fill count, the token valids and the handshake state; the
// stored edits are not cleared and are read only below the fill count.
// A request is taken only with no query in the row and the result register
// free or being drained in that cycle; a stalled result holds its value.
//
module edit_position_remapper_unit import epr_pkg::*; #(
   parameter int MAX_EDITS = EPR_MAX_EDITS
) (
   input  logic     clock,
   input  logic     reset,
   epr_req_if.sink  req_chan,
   epr_rsp_if.source rsp_chan
);

   localparam int CNT_W   = $clog2(MAX_EDITS + 1);
   // per-edit delta needs FIELD_W+2 bits, the sum one more bit per doubling
   localparam int DELTA_W = FIELD_W + 3 + $clog2(MAX_EDITS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WALK = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   epr_result_type       rsp_ff, rsp_in;

   logic                 req_xfer, is_query, is_full;
   epr_edit_type         wr_edit;
   logic                 wr_any;

   // chain taps; index 0 is the launch point
   logic                      tap_valid [0:MAX_EDITS];
   epr_tok_type               tap_tok   [0:MAX_EDITS];
   logic [CNT_W-1:0]          tap_rem   [0:MAX_EDITS];
   logic signed [DELTA_W-1:0] tap_ld    [0:MAX_EDITS];
   logic signed [DELTA_W-1:0] tap_cd    [0:MAX_EDITS];
   logic [MAX_EDITS-1:0]      cell_valid;

   logic                 walk_done;
   epr_result_type       walk_result;

   // request side
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign is_query       = (req_chan.kind == KIND_MAP_FWD) || (req_chan.kind == KIND_MAP_BACK);
   assign is_full        = (count_ff == CNT_W'(MAX_EDITS));
   assign wr_any         = req_xfer && (req_chan.kind == KIND_APPEND) && !is_full;

   always_comb begin
      wr_edit.orig_rng.bl = req_chan.orig_begin_line;
      wr_edit.orig_rng.bc = req_chan.orig_begin_col;
      wr_edit.orig_rng.el = req_chan.orig_end_line;
      wr_edit.orig_rng.ec = req_chan.orig_end_col;
      wr_edit.xfrm_rng.bl = req_chan.new_begin_line;
      wr_edit.xfrm_rng.bc = req_chan.new_begin_col;
      wr_edit.xfrm_rng.el = req_chan.new_end_line;
      wr_edit.xfrm_rng.ec = req_chan.new_end_col;
   end

   // launch token: fresh accumulators, remaining = current fill
   always_comb begin
      tap_valid[0]             = req_xfer && is_query;
      tap_tok[0].dir           = (req_chan.kind == KIND_MAP_BACK);
      tap_tok[0].ln            = req_chan.query_line;
      tap_tok[0].col           = req_chan.query_col;
      tap_tok[0].done          = 1'b0;
      tap_tok[0].snap          = 1'b0;
      tap_tok[0].snap_line     = '0;
      tap_tok[0].snap_col      = '0;
      tap_tok[0].track_valid   = 1'b0;
      tap_tok[0].track_line    = '0;
      tap_rem[0]               = count_ff;
      tap_ld[0]                = '0;
      tap_cd[0]                = '0;
   end

   // row of cells, cell i holds table entry i
   for (genvar i = 0; i < MAX_EDITS; i++) begin : g_row
      epr_walk_cell #(
         .CNT_W   (CNT_W),
         .DELTA_W (DELTA_W)
      ) u_walk (
         .clock         (clock),
         .reset         (reset),
         .wr_en         (wr_any && (count_ff == CNT_W'(i))),
         .wr_edit       (wr_edit),
         .up_valid      (tap_valid[i]),
         .up_tok        (tap_tok[i]),
         .up_rem        (tap_rem[i]),
         .up_line_delta (tap_ld[i]),
         .up_col_delta  (tap_cd[i]),
         .dn_valid      (tap_valid[i+1]),
         .dn_tok        (tap_tok[i+1]),
         .dn_rem        (tap_rem[i+1]),
         .dn_line_delta (tap_ld[i+1]),
         .dn_col_delta  (tap_cd[i+1])
      );
      assign cell_valid[i] = tap_valid[i+1];
   end

   assign walk_done = tap_valid[MAX_EDITS];

   // final add and clamp on the token leaving the last cell
   epr_resolve #(
      .DELTA_W (DELTA_W)
   ) u_resolve (
      .tok        (tap_tok[MAX_EDITS]),
      .line_delta (tap_ld[MAX_EDITS]),
      .col_delta  (tap_cd[MAX_EDITS]),
      .result     (walk_result)
   );

   // control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_chan.kind)
                  KIND_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end
                  KIND_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     if (is_full) begin
                        rsp_in.status = STAT_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_WALK;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (walk_done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = walk_result;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.mapped_line = rsp_ff.mapped_line;
   assign rsp_chan.mapped_col  = rsp_ff.mapped_col;
   assign rsp_chan.snapped     = rsp_ff.snapped;
   assign rsp_chan.status      = rsp_ff.status;

`ifndef SYNTH
   // fill count never passes the table depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EDITS))
      else $error("fill count beyond table depth");

   // at most one query token in the row
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cell_valid))
      else $error("more than one token in the cell row");

   // a token in the row means the controller is walking
   a_token_walk: assert property (@(posedge clock) disable iff (reset)
      (cell_valid != '0) |-> (state_ff == ST_WALK))
      else $error("token in row while controller idle");

   // the result register is free when a walk finishes
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      walk_done |-> !rsp_valid_ff)
      else $error("walk finished onto an occupied result register");
`endif

endmodule
